>>> sv/tla_pkg.sv
// ----------------------------------------------------------------------------
// tla_pkg
// Shared types and constants of the temperature limit alarm.
// ----------------------------------------------------------------------------
`default_nettype none

package tla_pkg;

    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TICKS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OK_SLOWDOWN = 4'd1;

    localparam logic [7:0] BLINK_TICKS_RESET = 8'd10;
    localparam logic [3:0] OK_SLOWDOWN_RESET = 4'd2;

    // Alarm status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HIGH     = 3'd1;
    localparam logic [2:0] ST_LOW      = 3'd2;
    localparam logic [2:0] ST_NOSENSOR = 3'd3;
    localparam logic [2:0] ST_WRONG    = 3'd4;

    localparam logic signed [7:0] NO_SENSOR_TEMP = -8'sd127;

    localparam logic [7:0] FAMILY_HALF_DEG = 8'h10;
    localparam logic [7:0] FAMILY_SIXTEENTH = 8'h28;

    localparam logic [7:0] LIMIT_MAG_MAX = 8'd99;

    localparam logic ACTION_TICK    = 1'b0;
    localparam logic ACTION_READING = 1'b1;

    typedef struct packed {
        logic       action;
        logic       presence_ok;
        logic [7:0] sensor_family;
        logic [7:0] scratch_low;
        logic [7:0] scratch_high;
        logic [7:0] low_switch_raw;
        logic [7:0] high_switch_raw;
        logic       low_sign_positive;
        logic       high_sign_positive;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        alarm_status;
        logic signed [7:0] measured_temp;
        logic              high_lamp;
        logic              low_lamp;
        logic              buzzer_on;
    } t_out_item;

    // Classified request passed from the front end to the back end.
    typedef struct packed {
        logic              is_reading;
        logic [2:0]        status;
        logic signed [7:0] temp;
    } t_cmd;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

`default_nettype wire

>>> sv/tla_front.sv
// ----------------------------------------------------------------------------
// tla_front
// Converts a reading to a temperature, decodes the limit switches and
// classifies the reading into an alarm status.
// ----------------------------------------------------------------------------
`default_nettype none

module tla_front (
    input  var tla_pkg::t_in_item i_item,
    output var tla_pkg::t_cmd     o_cmd
);

    logic [7:0]        lo_inv;
    logic [7:0]        hi_inv;
    logic [7:0]        lo_mag;
    logic [7:0]        hi_mag;
    logic signed [8:0] lo_lim;
    logic signed [8:0] hi_lim;
    logic signed [7:0] temp;
    logic signed [8:0] temp_w;
    logic [2:0]        status;

    // Switches are active low: low nibble is tens, high nibble is ones.
    assign lo_inv = ~i_item.low_switch_raw;
    assign hi_inv = ~i_item.high_switch_raw;
    assign lo_mag = 8'({4'd0, lo_inv[3:0]} * 8'd10) + {4'd0, lo_inv[7:4]};
    assign hi_mag = 8'({4'd0, hi_inv[3:0]} * 8'd10) + {4'd0, hi_inv[7:4]};
    assign lo_lim = i_item.low_sign_positive  ? $signed({1'b0, lo_mag})
                                              : -$signed({1'b0, lo_mag});
    assign hi_lim = i_item.high_sign_positive ? $signed({1'b0, hi_mag})
                                              : -$signed({1'b0, hi_mag});

    always_comb begin
        if (!i_item.presence_ok) begin
            temp = tla_pkg::NO_SENSOR_TEMP;
        end else if (i_item.sensor_family == tla_pkg::FAMILY_HALF_DEG) begin
            temp = $signed({i_item.scratch_high[7], i_item.scratch_low[7:1]});
        end else if (i_item.sensor_family == tla_pkg::FAMILY_SIXTEENTH) begin
            temp = $signed({i_item.scratch_high[3:0], i_item.scratch_low[7:4]});
        end else begin
            temp = tla_pkg::NO_SENSOR_TEMP;
        end
    end

    assign temp_w = {temp[7], temp};

    always_comb begin
        if (temp == tla_pkg::NO_SENSOR_TEMP) begin
            status = tla_pkg::ST_NOSENSOR;
        end else if ((lo_lim >= hi_lim) || (lo_mag > tla_pkg::LIMIT_MAG_MAX)
                     || (hi_mag > tla_pkg::LIMIT_MAG_MAX)) begin
            status = tla_pkg::ST_WRONG;
        end else if (temp_w < lo_lim) begin
            status = tla_pkg::ST_LOW;
        end else if (temp_w > hi_lim) begin
            status = tla_pkg::ST_HIGH;
        end else begin
            status = tla_pkg::ST_OK;
        end
    end

    assign o_cmd.is_reading = (i_item.action == tla_pkg::ACTION_READING);
    assign o_cmd.status     = status;
    assign o_cmd.temp       = temp;

endmodule

`default_nettype wire

>>> sv/tla_queue.sv
// ----------------------------------------------------------------------------
// tla_queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tla_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  var logic          i_clk,
    input  var logic          i_rst_n,
    input  var logic          i_wr_en,
    input  var tla_pkg::t_cmd i_wr_data,
    output var logic          o_full,
    output var logic          o_valid,
    input  var logic          i_rd_en,
    output var tla_pkg::t_cmd o_rd_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tla_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full    = (r_count == FULL_CNT);
    assign o_valid   = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_wr     = i_wr_en && !o_full;
    assign do_rd     = i_rd_en && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/tla_back.sv
// ----------------------------------------------------------------------------
// tla_back
// Holds the alarm state, applies classified requests and blink ticks, and
// keeps the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tla_back (
    input  var logic               i_clk,
    input  var logic               i_rst_n,
    input  var tla_pkg::t_cfg_wr   i_cfg,
    input  var logic               i_cmd_valid,
    input  var tla_pkg::t_cmd      i_cmd,
    output var logic               o_cmd_take,
    input  var logic               i_pop,
    output var logic               o_empty,
    output var tla_pkg::t_out_item o_out
);

    logic [7:0]        r_blink_ticks;
    logic [3:0]        r_ok_slowdown;
    logic [2:0]        r_status;
    logic signed [7:0] r_temp;
    logic [7:0]        r_tick_count;
    logic [3:0]        r_ok_count;
    logic              r_high_lamp;
    logic              r_low_lamp;
    logic              r_buzzer;
    logic              r_out_valid;
    tla_pkg::t_out_item r_out;

    logic [2:0]        n_status;
    logic signed [7:0] n_temp;
    logic [7:0]        n_tick_count;
    logic [3:0]        n_ok_count;
    logic              n_high_lamp;
    logic              n_low_lamp;
    logic              n_buzzer;
    logic [7:0]        tick_inc;
    logic [3:0]        ok_inc;
    logic              take;

    // A new request moves in whenever the output register is free or drains.
    assign take       = i_cmd_valid && (!r_out_valid || i_pop);
    assign o_cmd_take = take;
    assign o_empty    = !r_out_valid;
    assign o_out      = r_out;
    assign tick_inc   = r_tick_count + 8'd1;
    assign ok_inc     = r_ok_count + 4'd1;

    always_comb begin
        n_status     = r_status;
        n_temp       = r_temp;
        n_tick_count = r_tick_count;
        n_ok_count   = r_ok_count;
        n_high_lamp  = r_high_lamp;
        n_low_lamp   = r_low_lamp;
        n_buzzer     = r_buzzer;
        if (i_cmd.is_reading) begin
            n_status = i_cmd.status;
            n_temp   = i_cmd.temp;
        end else if (tick_inc < r_blink_ticks) begin
            n_tick_count = tick_inc;
        end else begin
            n_tick_count = '0;
            case (r_status)
                tla_pkg::ST_HIGH: begin
                    n_low_lamp  = 1'b0;
                    n_high_lamp = !r_high_lamp;
                    n_buzzer    = !r_high_lamp;
                end
                tla_pkg::ST_LOW: begin
                    n_high_lamp = 1'b0;
                    n_low_lamp  = !r_low_lamp;
                    n_buzzer    = !r_low_lamp;
                end
                tla_pkg::ST_WRONG: begin
                    n_high_lamp = 1'b1;
                    n_low_lamp  = 1'b1;
                    n_buzzer    = 1'b0;
                end
                tla_pkg::ST_NOSENSOR: begin
                    n_buzzer    = 1'b1;
                    n_high_lamp = !r_high_lamp;
                    n_low_lamp  = !r_high_lamp;
                end
                tla_pkg::ST_OK: begin
                    // In ok the blink toggles only once per ok_slowdown updates.
                    if (ok_inc >= r_ok_slowdown) begin
                        n_ok_count  = '0;
                        n_buzzer    = 1'b0;
                        n_high_lamp = !r_high_lamp;
                        n_low_lamp  = !r_high_lamp;
                    end else begin
                        n_ok_count = ok_inc;
                    end
                end
                default: begin
                    n_high_lamp = 1'b1;
                    n_low_lamp  = 1'b1;
                    n_buzzer    = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_ticks <= tla_pkg::BLINK_TICKS_RESET;
            r_ok_slowdown <= tla_pkg::OK_SLOWDOWN_RESET;
            r_status      <= tla_pkg::ST_OK;
            r_temp        <= '0;
            r_tick_count  <= '0;
            r_ok_count    <= '0;
            r_high_lamp   <= 1'b1;
            r_low_lamp    <= 1'b1;
            r_buzzer      <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.we && (i_cfg.index == tla_pkg::CFG_BLINK_TICKS)) begin
                r_blink_ticks <= i_cfg.data;
            end
            if (i_cfg.we && (i_cfg.index == tla_pkg::CFG_OK_SLOWDOWN)) begin
                r_ok_slowdown <= i_cfg.data[3:0];
            end
            if (take) begin
                r_status     <= n_status;
                r_temp       <= n_temp;
                r_tick_count <= n_tick_count;
                r_ok_count   <= n_ok_count;
                r_high_lamp  <= n_high_lamp;
                r_low_lamp   <= n_low_lamp;
                r_buzzer     <= n_buzzer;
                r_out_valid  <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.alarm_status  <= n_status;
            r_out.measured_temp <= n_temp;
            r_out.high_lamp     <= n_high_lamp;
            r_out.low_lamp      <= n_low_lamp;
            r_out.buzzer_on     <= n_buzzer;
        end
    end

endmodule

`default_nettype wire

>>> sv/temperature_limit_alarm_core.sv
// ----------------------------------------------------------------------------
// temperature_limit_alarm_core
// Temperature limit alarm with queue-style request and result ports.
// ----------------------------------------------------------------------------
// Every accepted request yields exactly one result, in order. A request is
// taken on every cycle in which full is low, so the block sustains one request
// per clock; a result passes through the request queue and then the output
// register. The front end classifies a reading combinationally; the back
// end updates the alarm state and loads
// the output register whenever that register is free or being popped, so a
// stalled result side fills the QUEUE_DEPTH-entry queue before full rises.
`default_nettype none

module temperature_limit_alarm_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  var logic                               i_clk,
    input  var logic                               i_rst_n,
    input  var logic                               push,
    output var logic                               full,
    input  var tla_pkg::t_in_item                  i_in,
    output var logic                               empty,
    input  var logic                               pop,
    output var tla_pkg::t_out_item                 o_out,
    input  var logic                               i_cfg_we,
    input  var logic [tla_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  var logic [tla_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    tla_pkg::t_cmd    front_cmd;
    tla_pkg::t_cmd    q_cmd;
    tla_pkg::t_cfg_wr cfg;
    logic             q_valid;
    logic             q_take;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    tla_front u_front (
        .i_item (i_in),
        .o_cmd  (front_cmd)
    );

    tla_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (push),
        .i_wr_data (front_cmd),
        .o_full    (full),
        .o_valid   (q_valid),
        .i_rd_en   (q_take),
        .o_rd_data (q_cmd)
    );

    tla_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_take  (q_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

>>> sv/tla_checker.sv
// ----------------------------------------------------------------------------
// tla_checker
// Port-level checks of the temperature limit alarm, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tla_checker (
    input  var logic                           i_clk,
    input  var logic                           i_rst_n,
    input  var logic                           push,
    input  var logic                           full,
    input  var logic                           empty,
    input  var logic                           pop,
    input  var tla_pkg::t_out_item             o_out
);

    // Reset leaves no result waiting and room for requests.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("result or full flag present after reset");

    // The queue can only fill behind a result that is held back.
    a_full_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("full while no result is waiting");

    // A waiting result that is not popped must not change.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out)))
        else $error("waiting result changed or vanished");

    // A missing sensor is always reported with its marker temperature.
    a_nosensor_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_out.alarm_status == tla_pkg::ST_NOSENSOR))
        |-> (o_out.measured_temp == tla_pkg::NO_SENSOR_TEMP))
        else $error("no sensor status with a real temperature");

    // Full can only rise after a request was pushed.
    a_full_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a request");

endmodule

bind temperature_limit_alarm_core tla_checker u_tla_checker (.*);

`default_nettype wire
